/* hw/rtl/pulse_width_key_frame_decoder_core_macros.svh */
// Assertion macros used by the checker file of the key frame decoder.
`ifndef PULSE_WIDTH_KEY_FRAME_DECODER_CORE_MACROS_SVH
`define PULSE_WIDTH_KEY_FRAME_DECODER_CORE_MACROS_SVH

// Checked only outside reset.
`define PWKFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked during reset as well.
`define PWKFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/pwkfd_pkg.sv */
// Types and constants of the pulse width key frame decoder.
package pwkfd_pkg;

  localparam int DefDurationBits = 16;
  localparam int DurationW       = 16;

  localparam logic [3:0] RepeatCountReset = 4'd2;
  localparam logic [7:0] PairLimitReset   = 8'd80;

  // Configuration register indices.
  typedef enum logic {
    CFG_REPEAT_COUNT = 1'b0,
    CFG_PAIR_LIMIT   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_LIMIT    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_BADCODE  = 3'd4
  } status_e;

  // 1-of-4 nibble codes.
  localparam logic [3:0] NibVal3 = 4'hE;
  localparam logic [3:0] NibVal2 = 4'hD;
  localparam logic [3:0] NibVal1 = 4'hB;
  localparam logic [3:0] NibVal0 = 4'h7;

  typedef struct packed {
    logic [DurationW-1:0] low_time;
    logic [DurationW-1:0] high_time;
    logic                 timed_out;
    logic                 new_read;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] raw_code;
    logic [15:0] key_code;
  } out_word_t;

endpackage

/* hw/rtl/pwkfd_key_decode.sv */
// Checks the eight 1-of-4 nibbles of a raw code and packs the key bytes.
module pwkfd_key_decode (
  input  logic [31:0] code_i,
  output logic [15:0] key_o,
  output logic        bad_o
);

  logic [1:0] val [8];
  logic [7:0] bad;

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      bad[n] = 1'b0;
      case (code_i[4*n +: 4])
        pwkfd_pkg::NibVal3: val[n] = 2'd3;
        pwkfd_pkg::NibVal2: val[n] = 2'd2;
        pwkfd_pkg::NibVal1: val[n] = 2'd1;
        pwkfd_pkg::NibVal0: val[n] = 2'd0;
        default: begin
          val[n] = 2'd0;
          bad[n] = 1'b1;
        end
      endcase
    end
  end

  // Byte 0 sits in the low bits of the code and gives the low nibble of the key.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      key_o[4*b +: 4] = {val[2*b+1], val[2*b]};
    end
  end

  assign bad_o = |bad;

endmodule

/* hw/rtl/pulse_width_key_frame_decoder_core.sv */
// Top level of the pulse width key frame decoder.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one word per measured
// low/high pulse pair, with the timeout and new-read flags alongside.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
// index 0 is the repeat count, index 1 the pair limit; always ready, and only
// to be written while the block is idle.
// Output channel (out_valid_o / out_ready_i / out_data_o): one word per read,
// carrying the status, the raw code of the first frame and the key bytes.
//
// Each pair is handled on its accepting edge: the frame state and, if the pair
// ends a read, the output register load on that edge, so the result is
// offered from the next cycle on, and one pair per cycle while no result stalls.
// The output register parts the channels: a new pair is accepted while a
// result waits, as long as that result is taken in the same cycle. When the
// receiver stalls with a result pending, in_ready_o drops until it is taken.
// Reset empties the output register, restores the register defaults
// (repeat count 2, pair limit 80) and makes the next pair an initial pair.
module pulse_width_key_frame_decoder_core #(
  parameter int DURATION_BITS = pwkfd_pkg::DefDurationBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pwkfd_pkg::in_word_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pwkfd_pkg::out_word_t  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  pwkfd_pkg::cfg_idx_e   cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  localparam int DurW     = pwkfd_pkg::DurationW;
  localparam int MaskBits = (DURATION_BITS < DurW) ? DURATION_BITS : DurW;
  localparam logic [DurW-1:0] DurMask =
    DurW'(((DurW+1)'(1) << MaskBits) - (DurW+1)'(1));

  typedef enum logic [1:0] {
    PH_IDLE, // waiting for the initial pair
    PH_DROP, // dropping the pair before a frame
    PH_HUNT, // looking for the start nibble
    PH_DATA  // shifting in the 32 data bits
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] window_q, window_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [2:0] byte_idx_q, byte_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] pair_cnt_q, pair_cnt_d;
  logic [3:0] frames_q, frames_d;
  logic [31:0] frame_q, frame_d;
  logic [31:0] first_q, first_d;

  logic [3:0] repeat_q;
  logic [7:0] limit_q;

  logic                 out_valid_q, res_valid;
  pwkfd_pkg::out_word_t out_q, res;

  logic [DurW-1:0] lo, hi;
  logic            tmo_lo, hi_zero, pair_bit;
  logic            in_fire;

  logic [31:0] dec_code;
  logic [15:0] dec_key;
  logic        dec_bad;

  // Intermediates of the step.
  phase_e     ph;
  logic [3:0] win;
  logic [7:0] sb;
  logic [3:0] bc;
  logic [2:0] bi;
  logic [31:0] fc;
  logic [7:0] pc;
  logic [3:0] fd;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign lo       = in_data_i.low_time & DurMask;
  assign hi       = in_data_i.high_time & DurMask;
  assign tmo_lo   = in_data_i.timed_out || (lo == '0);
  assign hi_zero  = (hi == '0);
  assign pair_bit = lo < hi;

  pwkfd_key_decode u_key_decode (
    .code_i (dec_code),
    .key_o  (dec_key),
    .bad_o  (dec_bad)
  );

  always_comb begin
    phase_d    = phase_q;
    window_d   = window_q;
    bit_cnt_d  = bit_cnt_q;
    byte_idx_d = byte_idx_q;
    shift_d    = shift_q;
    pair_cnt_d = pair_cnt_q;
    frames_d   = frames_q;
    frame_d    = frame_q;
    first_d    = first_q;
    res_valid  = 1'b0;
    res        = '{status: pwkfd_pkg::ST_OK, raw_code: '0, key_code: '0};

    ph  = in_data_i.new_read ? PH_IDLE : phase_q;
    win = window_q | {3'b000, pair_bit};
    sb  = {shift_q[6:0], pair_bit};
    bc  = bit_cnt_q + 4'd1;
    bi  = byte_idx_q + 3'd1;
    fc  = {frame_q[23:0], sb};
    pc  = pair_cnt_q + 8'd1;
    fd  = frames_q + 4'd1;
    // The first frame's code is written on the same edge it may be decoded.
    dec_code = (frames_q == 4'd0) ? fc : first_q;

    case (ph)
      PH_IDLE: begin
        if (tmo_lo || hi_zero) begin
          res_valid  = 1'b1;
          res.status = pwkfd_pkg::ST_TIMEOUT;
          phase_d    = PH_IDLE;
        end else begin
          frames_d = 4'd0;
          phase_d  = PH_DROP;
        end
      end
      PH_DROP: begin
        if (tmo_lo || hi_zero) begin
          res_valid  = 1'b1;
          res.status = pwkfd_pkg::ST_TIMEOUT;
          phase_d    = PH_IDLE;
        end else begin
          window_d   = 4'hF;
          bit_cnt_d  = 4'd0;
          byte_idx_d = 3'd0;
          shift_d    = 8'd0;
          pair_cnt_d = 8'd0;
          frame_d    = 32'd0;
          phase_d    = PH_HUNT;
        end
      end
      PH_HUNT, PH_DATA: begin
        if (tmo_lo) begin
          res_valid  = 1'b1;
          res.status = pwkfd_pkg::ST_TIMEOUT;
          phase_d    = PH_IDLE;
        end else begin
          pair_cnt_d = pc;
          if (pc == limit_q) begin
            res_valid  = 1'b1;
            res.status = pwkfd_pkg::ST_LIMIT;
            phase_d    = PH_IDLE;
          end else if (hi_zero) begin
            res_valid  = 1'b1;
            res.status = pwkfd_pkg::ST_TIMEOUT;
            phase_d    = PH_IDLE;
          end else if (ph == PH_HUNT) begin
            phase_d  = (win == 4'd1) ? PH_DATA : PH_HUNT;
            window_d = {win[2:0], 1'b0};
          end else if (bc < 4'd8) begin
            phase_d   = PH_DATA;
            shift_d   = sb;
            bit_cnt_d = bc;
          end else begin
            phase_d    = PH_DATA;
            frame_d    = fc;
            bit_cnt_d  = 4'd0;
            shift_d    = 8'd0;
            byte_idx_d = bi;
            if (bi >= 3'd4) begin
              if (frames_q == 4'd0) begin
                first_d = fc;
              end
              if ((frames_q != 4'd0) && (first_q != fc)) begin
                res_valid  = 1'b1;
                res.status = pwkfd_pkg::ST_MISMATCH;
                phase_d    = PH_IDLE;
              end else begin
                frames_d = fd;
                if (fd == repeat_q) begin
                  res_valid    = 1'b1;
                  res.raw_code = dec_code;
                  phase_d      = PH_IDLE;
                  if (dec_bad) begin
                    res.status = pwkfd_pkg::ST_BADCODE;
                  end else begin
                    res.key_code = dec_key;
                  end
                end else begin
                  phase_d = PH_DROP;
                end
              end
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      window_q    <= 4'hF;
      bit_cnt_q   <= 4'd0;
      byte_idx_q  <= 3'd0;
      shift_q     <= 8'd0;
      pair_cnt_q  <= 8'd0;
      frames_q    <= 4'd0;
      frame_q     <= 32'd0;
      repeat_q    <= pwkfd_pkg::RepeatCountReset;
      limit_q     <= pwkfd_pkg::PairLimitReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pwkfd_pkg::CFG_REPEAT_COUNT: repeat_q <= cfg_data_i[3:0];
          pwkfd_pkg::CFG_PAIR_LIMIT:   limit_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_q     <= phase_d;
        window_q    <= window_d;
        bit_cnt_q   <= bit_cnt_d;
        byte_idx_q  <= byte_idx_d;
        shift_q     <= shift_d;
        pair_cnt_q  <= pair_cnt_d;
        frames_q    <= frames_d;
        frame_q     <= frame_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload only: first code is read only after the first frame writes it.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      first_q <= first_d;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

endmodule

/* hw/rtl/pwkfd_checker.sv */
// Port-level checks of the key frame decoder and their binding.
`include "pulse_width_key_frame_decoder_core_macros.svh"

module pwkfd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input pwkfd_pkg::in_word_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input pwkfd_pkg::out_word_t out_data_o
);

  // A held result keeps its word.
  `PWKFD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // Input is blocked only by a pending result that is not being taken.
  `PWKFD_ASSERT(a_in_ready, in_ready_o == (!out_valid_o || out_ready_i), "input ready does not follow the output register")

  // Key bytes only with a good status; raw code only with good or bad-nibble status.
  `PWKFD_ASSERT(a_fields_zero, out_valid_o && (out_data_o.status != pwkfd_pkg::ST_OK) |-> (out_data_o.key_code == 16'd0) && ((out_data_o.status == pwkfd_pkg::ST_BADCODE) || (out_data_o.raw_code == 32'd0)), "fields not cleared for error status")

  // A timed-out initial pair gives a timeout result on the next cycle.
  `PWKFD_ASSERT(a_init_tmo, in_valid_i && in_ready_o && in_data_i.new_read && in_data_i.timed_out |=> out_valid_o && (out_data_o.status == pwkfd_pkg::ST_TIMEOUT), "missing timeout result")

  // An edge seen in reset leaves the output register empty by the next edge.
  `PWKFD_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind pulse_width_key_frame_decoder_core pwkfd_checker u_pwkfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
